>>> hdl/mfr_pkg.sv
// mfr_pkg: shared constants for the meter frame receiver.
// Widths, phase, status and result-kind codes, register indexes and register reset values.
// No dependencies.
package mfr_pkg;

	localparam int BYTE_W = 8;
	localparam int ADDR_W = 48;
	localparam int ADDR_LANES = ADDR_W / BYTE_W;
	localparam int PHASE_W = 4;
	localparam int STATUS_W = 3;
	localparam int CFG_IDX_W = 2;

	// receive phases
	localparam logic [PHASE_W-1:0] PH_HUNT = 4'd0;
	localparam logic [PHASE_W-1:0] PH_ADDR = 4'd1;
	localparam logic [PHASE_W-1:0] PH_MID  = 4'd2;
	localparam logic [PHASE_W-1:0] PH_CTRL = 4'd3;
	localparam logic [PHASE_W-1:0] PH_LEN  = 4'd4;
	localparam logic [PHASE_W-1:0] PH_DATA = 4'd5;
	localparam logic [PHASE_W-1:0] PH_SUM  = 4'd6;
	localparam logic [PHASE_W-1:0] PH_END  = 4'd7;

	// frame report status
	localparam logic [STATUS_W-1:0] ST_GOOD      = 3'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_START = 3'd1;
	localparam logic [STATUS_W-1:0] ST_OVER_LEN  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_BAD_SUM   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_BAD_END   = 3'd4;

	// result kinds
	localparam logic KIND_DATA   = 1'b0;
	localparam logic KIND_REPORT = 1'b1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_START_BYTE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_END_BYTE     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DATA_OFFSET  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DATA_LEN = 2'd3;

	// register reset values
	localparam logic [BYTE_W-1:0] RST_START_BYTE   = 8'h68;
	localparam logic [BYTE_W-1:0] RST_END_BYTE     = 8'h16;
	localparam logic [BYTE_W-1:0] RST_DATA_OFFSET  = 8'h33;
	localparam logic [BYTE_W-1:0] RST_MAX_DATA_LEN = 8'd200;

endpackage

>>> hdl/meter_frame_receiver_core.sv
// meter_frame_receiver_core: byte-serial meter frame deframer.
// Takes one line byte per item, emits descrambled data bytes and frame reports.
// Uses mfr_pkg for phase, status and register codes.
//
// Usage:
//  - Input channel: in_valid / in_stall with rx_byte. One received line byte
//    per item. Bytes outside a frame are dropped while hunting for start_byte.
//  - Output channel: out_valid / out_stall. A data item (kind 0) carries one
//    data byte with data_offset removed and its index; a report (kind 1)
//    closes or drops a frame and carries address, control, length, status.
//  - An input byte yields zero or one result, which is registered: it is in
//    the output register the cycle after the byte is taken.
//  - Throughput is one byte per cycle unless stalled; the phase update is
//    a short add and compare, and one output register decouples the sides.
//  - When the receiver stalls with a result held, in_stall rises and the
//    frame state waits; it drops again the cycle the result is taken.
//  - Configuration: cfg_we writes cfg_data[7:0] to register cfg_index
//    (0 start byte, 1 end byte, 2 data offset, 3 max data length).
//    Write only while the block is idle.
//  - Reset (arst_n low) puts the registers at their defaults, the deframer
//    back to hunting with cleared address, control, length and sum, and
//    empties the output register.
module meter_frame_receiver_core #(
	parameter int ADDRESS_BYTES = 6
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              cfg_we,
	input  logic [mfr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mfr_pkg::BYTE_W-1:0]        cfg_data,
	// input channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [mfr_pkg::BYTE_W-1:0]        rx_byte,
	// output channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              kind,
	output logic [mfr_pkg::BYTE_W-1:0]        data_byte,
	output logic [mfr_pkg::BYTE_W-1:0]        data_index,
	output logic [mfr_pkg::ADDR_W-1:0]        meter_address,
	output logic [mfr_pkg::BYTE_W-1:0]        control_code,
	output logic [mfr_pkg::BYTE_W-1:0]        frame_length,
	output logic [mfr_pkg::STATUS_W-1:0]      frame_status
);

	localparam logic [mfr_pkg::BYTE_W-1:0] ADDR_LAST = mfr_pkg::BYTE_W'(ADDRESS_BYTES);

	// configuration registers
	logic [mfr_pkg::BYTE_W-1:0] start_byte_q;
	logic [mfr_pkg::BYTE_W-1:0] end_byte_q;
	logic [mfr_pkg::BYTE_W-1:0] data_offset_q;
	logic [mfr_pkg::BYTE_W-1:0] max_data_len_q;

	// frame state
	logic [mfr_pkg::PHASE_W-1:0] phase_q, phase_nxt;
	logic [mfr_pkg::BYTE_W-1:0]  byte_count_q, byte_count_nxt;
	logic [mfr_pkg::BYTE_W-1:0]  running_sum_q, running_sum_nxt;
	logic [mfr_pkg::ADDR_W-1:0]  address_q, address_nxt;
	logic [mfr_pkg::BYTE_W-1:0]  control_q, control_nxt;
	logic [mfr_pkg::BYTE_W-1:0]  length_q, length_nxt;

	// result of the current byte
	logic                         res_valid;
	logic                         res_kind;
	logic [mfr_pkg::BYTE_W-1:0]   res_dbyte;
	logic [mfr_pkg::BYTE_W-1:0]   res_didx;
	logic [mfr_pkg::STATUS_W-1:0] res_status;

	logic [mfr_pkg::BYTE_W-1:0] sum_add;
	logic [mfr_pkg::BYTE_W-1:0] count_inc;
	logic                       in_acc;
	logic                       out_free;

	// output register is free when empty or being taken this cycle
	assign out_free = !out_valid || !out_stall;
	assign in_stall = !out_free;
	assign in_acc   = in_valid && out_free;

	assign sum_add   = running_sum_q + rx_byte;
	assign count_inc = byte_count_q + 8'd1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q   <= mfr_pkg::RST_START_BYTE;
			end_byte_q     <= mfr_pkg::RST_END_BYTE;
			data_offset_q  <= mfr_pkg::RST_DATA_OFFSET;
			max_data_len_q <= mfr_pkg::RST_MAX_DATA_LEN;
		end else if (cfg_we) begin
			case (cfg_index)
				mfr_pkg::REG_START_BYTE:   start_byte_q   <= cfg_data;
				mfr_pkg::REG_END_BYTE:     end_byte_q     <= cfg_data;
				mfr_pkg::REG_DATA_OFFSET:  data_offset_q  <= cfg_data;
				mfr_pkg::REG_MAX_DATA_LEN: max_data_len_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// per-byte phase update
	always_comb begin
		phase_nxt       = phase_q;
		byte_count_nxt  = byte_count_q;
		running_sum_nxt = running_sum_q;
		address_nxt     = address_q;
		control_nxt     = control_q;
		length_nxt      = length_q;
		res_valid       = 1'b0;
		res_kind        = mfr_pkg::KIND_DATA;
		res_dbyte       = '0;
		res_didx        = '0;
		res_status      = mfr_pkg::ST_GOOD;

		case (phase_q)
			mfr_pkg::PH_ADDR: begin
				// address bytes land low byte first; lanes past 48 bits are lost
				for (int i = 0; i < mfr_pkg::ADDR_LANES; i++) begin
					if (byte_count_q[2:0] == 3'(i))
						address_nxt[i*mfr_pkg::BYTE_W +: mfr_pkg::BYTE_W] =
							address_q[i*mfr_pkg::BYTE_W +: mfr_pkg::BYTE_W] | rx_byte;
				end
				running_sum_nxt = sum_add;
				byte_count_nxt  = count_inc;
				if (count_inc >= ADDR_LAST)
					phase_nxt = mfr_pkg::PH_MID;
			end
			mfr_pkg::PH_MID: begin
				if (rx_byte != start_byte_q) begin
					phase_nxt  = mfr_pkg::PH_HUNT;
					res_valid  = 1'b1;
					res_kind   = mfr_pkg::KIND_REPORT;
					res_status = mfr_pkg::ST_BAD_START;
				end else begin
					running_sum_nxt = sum_add;
					phase_nxt       = mfr_pkg::PH_CTRL;
				end
			end
			mfr_pkg::PH_CTRL: begin
				control_nxt     = rx_byte;
				running_sum_nxt = sum_add;
				phase_nxt       = mfr_pkg::PH_LEN;
			end
			mfr_pkg::PH_LEN: begin
				length_nxt      = rx_byte;
				running_sum_nxt = sum_add;
				if (rx_byte > max_data_len_q) begin
					phase_nxt  = mfr_pkg::PH_HUNT;
					res_valid  = 1'b1;
					res_kind   = mfr_pkg::KIND_REPORT;
					res_status = mfr_pkg::ST_OVER_LEN;
				end else begin
					byte_count_nxt = '0;
					phase_nxt = (rx_byte == '0) ? mfr_pkg::PH_SUM : mfr_pkg::PH_DATA;
				end
			end
			mfr_pkg::PH_DATA: begin
				running_sum_nxt = sum_add;
				res_valid       = 1'b1;
				res_dbyte       = rx_byte - data_offset_q;
				res_didx        = byte_count_q;
				byte_count_nxt  = count_inc;
				if (count_inc >= length_q)
					phase_nxt = mfr_pkg::PH_SUM;
			end
			mfr_pkg::PH_SUM: begin
				// sum goes to zero exactly when the checksum byte matches
				running_sum_nxt = running_sum_q ^ rx_byte;
				phase_nxt       = mfr_pkg::PH_END;
			end
			mfr_pkg::PH_END: begin
				phase_nxt = mfr_pkg::PH_HUNT;
				res_valid = 1'b1;
				res_kind  = mfr_pkg::KIND_REPORT;
				if (rx_byte != end_byte_q)
					res_status = mfr_pkg::ST_BAD_END;
				else if (running_sum_q != '0)
					res_status = mfr_pkg::ST_BAD_SUM;
				else
					res_status = mfr_pkg::ST_GOOD;
			end
			default: begin
				// hunting, and any unused code
				phase_nxt = mfr_pkg::PH_HUNT;
				if (rx_byte == start_byte_q) begin
					running_sum_nxt = rx_byte;
					byte_count_nxt  = '0;
					address_nxt     = '0;
					control_nxt     = '0;
					length_nxt      = '0;
					phase_nxt       = mfr_pkg::PH_ADDR;
				end
			end
		endcase
	end

	// frame state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= mfr_pkg::PH_HUNT;
			byte_count_q  <= '0;
			running_sum_q <= '0;
			address_q     <= '0;
			control_q     <= '0;
			length_q      <= '0;
		end else if (in_acc) begin
			phase_q       <= phase_nxt;
			byte_count_q  <= byte_count_nxt;
			running_sum_q <= running_sum_nxt;
			address_q     <= address_nxt;
			control_q     <= control_nxt;
			length_q      <= length_nxt;
		end
	end

	// output register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= in_acc && res_valid;
		end
	end

	// output register: payload, loaded only with a new result
	always_ff @(posedge clk) begin
		if (in_acc && res_valid) begin
			kind          <= res_kind;
			data_byte     <= res_dbyte;
			data_index    <= res_didx;
			meter_address <= address_nxt;
			control_code  <= control_nxt;
			frame_length  <= length_nxt;
			frame_status  <= res_status;
		end
	end

	// a data byte always produces a result in the next cycle
	a_data_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && phase_q == mfr_pkg::PH_DATA) |=> (out_valid && kind == mfr_pkg::KIND_DATA))
		else $error("data byte did not produce a data result");

	// data results carry good status and an index inside the frame length
	a_data_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == mfr_pkg::KIND_DATA) |->
			(frame_status == mfr_pkg::ST_GOOD && data_index < frame_length))
		else $error("data result fields inconsistent");

	// a byte taken while hunting never yields a result
	a_hunt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && phase_q == mfr_pkg::PH_HUNT) |=> !out_valid)
		else $error("result produced while hunting");

endmodule

>>> dv/tb_meter_frame_receiver_core.sv
`timescale 1ns / 100ps
// tb_meter_frame_receiver_core: self-checking bench for the meter frame deframer.
// Drives line bytes through valid/stall, predicts data items and frame reports,
// and checks them field by field. Depends on mfr_pkg and meter_frame_receiver_core.
module tb_meter_frame_receiver_core;

	localparam int ADDR_BYTES  = 6;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE      = 4;	// output register latency plus margin

	// frame corruption applied by the generator
	typedef enum int {FL_NONE, FL_MID, FL_LONG, FL_SUM, FL_END, FL_BOTH} flaw_t;

	typedef struct packed {
		logic                          kind;
		logic [mfr_pkg::BYTE_W-1:0]    data_byte;
		logic [mfr_pkg::BYTE_W-1:0]    data_index;
		logic [mfr_pkg::ADDR_W-1:0]    meter_address;
		logic [mfr_pkg::BYTE_W-1:0]    control_code;
		logic [mfr_pkg::BYTE_W-1:0]    frame_length;
		logic [mfr_pkg::STATUS_W-1:0]  frame_status;
	} deframe_result_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_we = 1'b0;
	logic [mfr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [mfr_pkg::BYTE_W-1:0]     cfg_data = '0;
	logic                           in_valid = 1'b0;
	logic                           in_stall;
	logic [mfr_pkg::BYTE_W-1:0]     rx_byte = '0;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	logic                           kind;
	logic [mfr_pkg::BYTE_W-1:0]     data_byte;
	logic [mfr_pkg::BYTE_W-1:0]     data_index;
	logic [mfr_pkg::ADDR_W-1:0]     meter_address;
	logic [mfr_pkg::BYTE_W-1:0]     control_code;
	logic [mfr_pkg::BYTE_W-1:0]     frame_length;
	logic [mfr_pkg::STATUS_W-1:0]   frame_status;

	meter_frame_receiver_core #(
		.ADDRESS_BYTES(ADDR_BYTES)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.data_byte(data_byte),
		.data_index(data_index),
		.meter_address(meter_address),
		.control_code(control_code),
		.frame_length(frame_length),
		.frame_status(frame_status)
	);

	// bytes waiting for the driver, and deframer outputs still owed by the DUT
	logic [mfr_pkg::BYTE_W-1:0]  line_bytes_q[$];
	deframe_result_t             deframed_q[$];

	// register copies used by the generator and the predictor
	logic [mfr_pkg::BYTE_W-1:0]  start_b;
	logic [mfr_pkg::BYTE_W-1:0]  end_b;
	logic [mfr_pkg::BYTE_W-1:0]  offset_b;
	logic [mfr_pkg::BYTE_W-1:0]  max_len;

	// predictor's view of the frame in progress
	logic [mfr_pkg::PHASE_W-1:0] rx_phase;
	logic [mfr_pkg::BYTE_W-1:0]  rx_count;
	logic [mfr_pkg::BYTE_W-1:0]  rx_sum;
	logic [mfr_pkg::ADDR_W-1:0]  rx_addr;
	logic [mfr_pkg::BYTE_W-1:0]  rx_ctrl;
	logic [mfr_pkg::BYTE_W-1:0]  rx_len;

	int idle_pct = 0;	// sender idle chance, percent
	int stall_pct = 0;	// receiver stall chance, percent
	int mismatches = 0;
	int lines_sent = 0;
	int frames_built = 0;
	int data_checked = 0;
	int reports_checked = 0;
	int cycle_count = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	// Result as the deframer would present it now: address, control and
	// length always reflect the frame collected so far.
	function automatic deframe_result_t frame_result(input logic k, input logic [7:0] db,
			input logic [7:0] di, input logic [mfr_pkg::STATUS_W-1:0] st);
		deframe_result_t r;
		r.kind = k;
		r.data_byte = db;
		r.data_index = di;
		r.meter_address = rx_addr;
		r.control_code = rx_ctrl;
		r.frame_length = rx_len;
		r.frame_status = st;
		return r;
	endfunction

	// Advance the frame state by one accepted line byte and queue what it yields.
	task automatic deframe_byte(input logic [mfr_pkg::BYTE_W-1:0] b);
		logic [63:0] wide;
		case (rx_phase)
		mfr_pkg::PH_ADDR: begin
			// first address byte lands in the low byte; anything past 48 bits falls off
			wide = {16'h0, rx_addr} | (64'(b) << (8 * int'(rx_count & 8'd7)));
			rx_addr = wide[mfr_pkg::ADDR_W-1:0];
			rx_sum = rx_sum + b;
			rx_count = rx_count + 8'd1;
			if (rx_count >= ADDR_BYTES)
				rx_phase = mfr_pkg::PH_MID;
		end
		mfr_pkg::PH_MID: begin
			if (b != start_b) begin
				// the offending byte is consumed, not taken as a fresh start
				rx_phase = mfr_pkg::PH_HUNT;
				deframed_q.push_back(frame_result(mfr_pkg::KIND_REPORT, 8'h0, 8'h0,
					mfr_pkg::ST_BAD_START));
			end else begin
				rx_sum = rx_sum + b;
				rx_phase = mfr_pkg::PH_CTRL;
			end
		end
		mfr_pkg::PH_CTRL: begin
			rx_ctrl = b;
			rx_sum = rx_sum + b;
			rx_phase = mfr_pkg::PH_LEN;
		end
		mfr_pkg::PH_LEN: begin
			rx_len = b;
			rx_sum = rx_sum + b;
			if (b > max_len) begin
				rx_phase = mfr_pkg::PH_HUNT;
				deframed_q.push_back(frame_result(mfr_pkg::KIND_REPORT, 8'h0, 8'h0,
					mfr_pkg::ST_OVER_LEN));
			end else begin
				rx_count = 8'h0;
				rx_phase = (b == 8'h0) ? mfr_pkg::PH_SUM : mfr_pkg::PH_DATA;
			end
		end
		mfr_pkg::PH_DATA: begin
			rx_sum = rx_sum + b;
			deframed_q.push_back(frame_result(mfr_pkg::KIND_DATA, b - offset_b, rx_count,
				mfr_pkg::ST_GOOD));
			rx_count = rx_count + 8'd1;
			if (rx_count >= rx_len)
				rx_phase = mfr_pkg::PH_SUM;
		end
		mfr_pkg::PH_SUM: begin
			// zero exactly when the sum byte matches; verdict waits for the end byte
			rx_sum = rx_sum ^ b;
			rx_phase = mfr_pkg::PH_END;
		end
		mfr_pkg::PH_END: begin
			rx_phase = mfr_pkg::PH_HUNT;
			// a bad end byte outranks a bad sum
			if (b != end_b)
				deframed_q.push_back(frame_result(mfr_pkg::KIND_REPORT, 8'h0, 8'h0,
					mfr_pkg::ST_BAD_END));
			else if (rx_sum != 8'h0)
				deframed_q.push_back(frame_result(mfr_pkg::KIND_REPORT, 8'h0, 8'h0,
					mfr_pkg::ST_BAD_SUM));
			else
				deframed_q.push_back(frame_result(mfr_pkg::KIND_REPORT, 8'h0, 8'h0,
					mfr_pkg::ST_GOOD));
		end
		default: begin
			rx_phase = mfr_pkg::PH_HUNT;
			if (b == start_b) begin
				rx_sum = b;
				rx_count = 8'h0;
				rx_addr = '0;
				rx_ctrl = 8'h0;
				rx_len = 8'h0;
				rx_phase = mfr_pkg::PH_ADDR;
			end
		end
		endcase
	endtask

	// Register write at a clock edge; the local copy follows.
	task automatic write_reg(input logic [mfr_pkg::CFG_IDX_W-1:0] idx,
			input logic [mfr_pkg::BYTE_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
		mfr_pkg::REG_START_BYTE:   start_b = val;
		mfr_pkg::REG_END_BYTE:     end_b = val;
		mfr_pkg::REG_DATA_OFFSET:  offset_b = val;
		mfr_pkg::REG_MAX_DATA_LEN: max_len = val;
		default: ;
		endcase
	endtask

	task automatic set_config(input logic [7:0] s, input logic [7:0] e, input logic [7:0] o,
			input logic [7:0] m);
		write_reg(mfr_pkg::REG_START_BYTE, s);
		write_reg(mfr_pkg::REG_END_BYTE, e);
		write_reg(mfr_pkg::REG_DATA_OFFSET, o);
		write_reg(mfr_pkg::REG_MAX_DATA_LEN, m);
	endtask

	// Idle means: nothing left to send, nothing on the wire, nothing owed back.
	// The extra cycles cover bytes that yield no result but may still be in flight.
	task automatic wait_idle();
		while (line_bytes_q.size() != 0 || in_valid || deframed_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic void put_line(input logic [7:0] b, inout logic [7:0] sum,
			inout int count);
		line_bytes_q.push_back(b);
		sum = sum + b;
		count++;
	endfunction

	// Queue one frame. fill >= 0 fixes address, control and data bytes;
	// len_req >= 0 fixes the length byte. Broken frames stop where the
	// deframer gives up on them.
	task automatic queue_frame(input flaw_t flaw, input int fill, input int len_req,
			output int count);
		logic [7:0] sum;
		logic [7:0] len;
		logic [7:0] b;
		int i;
		flaw_t f;
		f = flaw;
		count = 0;
		if (f == FL_LONG && max_len == 8'hFF)
			f = FL_NONE;
		if (len_req >= 0)
			len = 8'(len_req);
		else if (f == FL_LONG)
			len = 8'($urandom_range(255, int'(max_len) + 1));
		else if ($urandom_range(15) == 0)
			len = 8'($urandom_range(int'(max_len), 0));
		else
			len = 8'($urandom_range(max_len < 8'd8 ? int'(max_len) : 8, 0));
		frames_built++;
		sum = 8'h0;
		put_line(start_b, sum, count);
		for (i = 0; i < ADDR_BYTES; i++) begin
			b = (fill >= 0) ? 8'(fill) : 8'($urandom);
			put_line(b, sum, count);
		end
		if (f == FL_MID) begin
			put_line(start_b ^ 8'($urandom_range(255, 1)), sum, count);
			return;
		end
		put_line(start_b, sum, count);
		b = (fill >= 0) ? 8'(fill) : 8'($urandom);
		put_line(b, sum, count);
		put_line(len, sum, count);
		if (f == FL_LONG)
			return;
		for (i = 0; i < int'(len); i++) begin
			b = (fill >= 0) ? 8'(fill) : 8'($urandom);
			put_line(b, sum, count);
		end
		b = sum;
		if (f == FL_SUM || f == FL_BOTH)
			b = b ^ 8'($urandom_range(255, 1));
		put_line(b, sum, count);
		b = end_b;
		if (f == FL_END || f == FL_BOTH)
			b = b ^ 8'($urandom_range(255, 1));
		put_line(b, sum, count);
	endtask

	// Well-formed frames with random content half the time, broken frames the
	// rest, and stray line noise between them. Noise is not counted toward budget.
	task automatic queue_random(input int budget);
		int n;
		int k;
		int j;
		int c;
		n = 0;
		while (n < budget) begin
			if ($urandom_range(4) == 0) begin
				k = $urandom_range(3, 1);
				for (j = 0; j < k; j++)
					line_bytes_q.push_back(8'($urandom));
			end
			k = $urandom_range(9);
			queue_frame((k < 5) ? FL_NONE : flaw_t'(k - 4), -1, -1, c);
			n += c;
		end
	endtask

	// Driver: present the next byte once the current one is taken.
	// The predictor runs on the edge where the byte is accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			rx_byte <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				deframe_byte(rx_byte);
				lines_sent++;
			end
			if (!in_valid || !in_stall) begin
				if (line_bytes_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
					in_valid <= 1'b1;
					rx_byte <= line_bytes_q.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic flag_field(input string field, input logic [63:0] want,
			input logic [63:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch in %s: expected %0h, got %0h (after %0d results)", field,
				want, got, data_checked + reports_checked);
	endtask

	// Monitor: random back-pressure, and every taken result checked in order.
	always @(posedge clk or negedge arst_n) begin
		deframe_result_t got;
		deframe_result_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				got = {kind, data_byte, data_index, meter_address, control_code,
					frame_length, frame_status};
				if (deframed_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: kind %0d status %0d data %0h",
							got.kind, got.frame_status, got.data_byte);
				end else begin
					want = deframed_q.pop_front();
					if (got.kind !== want.kind)
						flag_field("kind", want.kind, got.kind);
					if (got.data_byte !== want.data_byte)
						flag_field("data_byte", want.data_byte, got.data_byte);
					if (got.data_index !== want.data_index)
						flag_field("data_index", want.data_index, got.data_index);
					if (got.meter_address !== want.meter_address)
						flag_field("meter_address", want.meter_address, got.meter_address);
					if (got.control_code !== want.control_code)
						flag_field("control_code", want.control_code, got.control_code);
					if (got.frame_length !== want.frame_length)
						flag_field("frame_length", want.frame_length, got.frame_length);
					if (got.frame_status !== want.frame_status)
						flag_field("frame_status", want.frame_status, got.frame_status);
					if (want.kind == mfr_pkg::KIND_DATA)
						data_checked++;
					else
						reports_checked++;
				end
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		int c;
		start_b = mfr_pkg::RST_START_BYTE;
		end_b = mfr_pkg::RST_END_BYTE;
		offset_b = mfr_pkg::RST_DATA_OFFSET;
		max_len = mfr_pkg::RST_MAX_DATA_LEN;
		rx_phase = mfr_pkg::PH_HUNT;
		rx_count = 8'h0;
		rx_sum = 8'h0;
		rx_addr = '0;
		rx_ctrl = 8'h0;
		rx_len = 8'h0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Reset defaults, no idling. Directed: noise at both byte extremes while
		// hunting, a good frame of all-ones bytes, then a bad second start.
		line_bytes_q.push_back(8'h00);
		line_bytes_q.push_back(8'hFF);
		queue_frame(FL_NONE, 8'hFF, 2, c);
		queue_frame(FL_MID, 8'h00, -1, c);
		queue_random(150);
		wait_idle();

		// Low extremes: zero start, no offset, only zero-length frames accepted.
		idle_pct = 78;
		set_config(8'h00, 8'hFF, 8'h00, 8'h00);
		queue_random(175);
		wait_idle();

		// High extremes: any length goes, receiver mostly stalled.
		idle_pct = 0;
		stall_pct = 78;
		set_config(8'hFF, 8'h00, 8'hFF, 8'hFF);
		queue_random(175);
		wait_idle();

		idle_pct = 29;
		stall_pct = 29;
		set_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
		queue_random(175);
		wait_idle();

		// back to the reset values, written explicitly
		idle_pct = 0;
		stall_pct = 0;
		set_config(mfr_pkg::RST_START_BYTE, mfr_pkg::RST_END_BYTE, mfr_pkg::RST_DATA_OFFSET,
			mfr_pkg::RST_MAX_DATA_LEN);
		queue_random(175);
		wait_idle();

		idle_pct = 78;
		set_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom_range(40)));
		queue_random(175);
		wait_idle();

		idle_pct = 0;
		stall_pct = 78;
		set_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
		queue_random(175);
		wait_idle();

		idle_pct = 29;
		stall_pct = 29;
		set_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom_range(12)));
		queue_random(175);
		wait_idle();

		$display("Sent %0d line bytes (%0d frames built) over 8 register settings",
			lines_sent, frames_built);
		$display("Checked %0d data items and %0d frame reports; %0d mismatches",
			data_checked, reports_checked, mismatches);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
